// File: rtl/gdhq_pkg.sv
// Shared types, register map, gaze codes and code/sign tables for the
// gaze direction hysteresis quantizer. Depends on nothing.
package gdhq_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int THR_W           = 15;
  localparam int RATIO_W         = 9;
  localparam int HOLD_W          = THR_W + RATIO_W;
  localparam int CFG_DW          = 32;
  localparam int CFG_AW          = 5;
  localparam int IDX_W           = 3;
  localparam int CODE_W          = 4;

  // Register indexes, at byte address 4*index.
  localparam logic [IDX_W-1:0] REG_PITCH_THR = 3'd0;
  localparam logic [IDX_W-1:0] REG_TILT_THR  = 3'd1;
  localparam logic [IDX_W-1:0] REG_DEADBAND  = 3'd2;
  localparam logic [IDX_W-1:0] REG_EXIT_RAT  = 3'd3;
  localparam logic [IDX_W-1:0] REG_VY_GAIN   = 3'd4;
  localparam logic [IDX_W-1:0] REG_WZ_GAIN   = 3'd5;
  localparam logic [IDX_W-1:0] REG_ZERO_TOL  = 3'd6;

  localparam logic [THR_W-1:0]   RST_PITCH_THR = 15'd1024;
  localparam logic [THR_W-1:0]   RST_TILT_THR  = 15'd1024;
  localparam logic [THR_W-1:0]   RST_DEADBAND  = 15'd1228;
  localparam logic [RATIO_W-1:0] RST_EXIT_RAT  = 9'd179;
  localparam logic [THR_W-1:0]   RST_VY_GAIN   = 15'd8192;
  localparam logic [THR_W-1:0]   RST_WZ_GAIN   = 15'd4096;
  localparam logic [THR_W-1:0]   RST_ZERO_TOL  = 15'd4;

  localparam logic [CODE_W-1:0] GAZE_CENTER     = 4'd0;
  localparam logic [CODE_W-1:0] GAZE_UP         = 4'd1;
  localparam logic [CODE_W-1:0] GAZE_DOWN       = 4'd2;
  localparam logic [CODE_W-1:0] GAZE_LEFT       = 4'd3;
  localparam logic [CODE_W-1:0] GAZE_RIGHT      = 4'd4;
  localparam logic [CODE_W-1:0] GAZE_UP_LEFT    = 4'd5;
  localparam logic [CODE_W-1:0] GAZE_UP_RIGHT   = 4'd6;
  localparam logic [CODE_W-1:0] GAZE_DOWN_LEFT  = 4'd7;
  localparam logic [CODE_W-1:0] GAZE_DOWN_RIGHT = 4'd8;

  // A ternary sign: nz clear means zero, else pos gives the direction.
  typedef struct packed {
    logic nz;
    logic pos;
  } sign_t;

  // Configuration as seen by the datapath, with the hold levels
  // (enter level times exit ratio) already multiplied out.
  typedef struct packed {
    logic [THR_W-1:0]  pitch_thr;
    logic [THR_W-1:0]  tilt_thr;
    logic [THR_W-1:0]  deadband;
    logic [THR_W-1:0]  vy_gain;
    logic [THR_W-1:0]  wz_gain;
    logic [THR_W-1:0]  zero_tol;
    logic [HOLD_W-1:0] pitch_hold;
    logic [HOLD_W-1:0] tilt_hold;
    logic [HOLD_W-1:0] deadband_hold;
  } cfg_t;

  function automatic sign_t vert_of_code(input logic [CODE_W-1:0] code);
    sign_t s;
    unique case (code)
      GAZE_UP, GAZE_UP_LEFT, GAZE_UP_RIGHT:        s = '{nz: 1'b1, pos: 1'b1};
      GAZE_DOWN, GAZE_DOWN_LEFT, GAZE_DOWN_RIGHT:  s = '{nz: 1'b1, pos: 1'b0};
      default:                                     s = '{nz: 1'b0, pos: 1'b0};
    endcase
    return s;
  endfunction

  // Positive horizontal direction is left.
  function automatic sign_t horz_of_code(input logic [CODE_W-1:0] code);
    sign_t s;
    unique case (code)
      GAZE_LEFT, GAZE_UP_LEFT, GAZE_DOWN_LEFT:     s = '{nz: 1'b1, pos: 1'b1};
      GAZE_RIGHT, GAZE_UP_RIGHT, GAZE_DOWN_RIGHT:  s = '{nz: 1'b1, pos: 1'b0};
      default:                                     s = '{nz: 1'b0, pos: 1'b0};
    endcase
    return s;
  endfunction

  function automatic logic [CODE_W-1:0] code_of_signs(input sign_t v, input sign_t h);
    logic [CODE_W-1:0] code;
    if (!v.nz) begin
      code = !h.nz ? GAZE_CENTER : (h.pos ? GAZE_LEFT : GAZE_RIGHT);
    end else if (v.pos) begin
      code = !h.nz ? GAZE_UP : (h.pos ? GAZE_UP_LEFT : GAZE_UP_RIGHT);
    end else begin
      code = !h.nz ? GAZE_DOWN : (h.pos ? GAZE_DOWN_LEFT : GAZE_DOWN_RIGHT);
    end
    return code;
  endfunction

endpackage

// File: rtl/gaze_direction_hysteresis_quantizer.sv
// Top level of the gaze direction hysteresis quantizer: stream handshake,
// single-pass datapath and the last-gaze register. Depends on gdhq_pkg,
// gdhq_cfg and gdhq_hyst.

// One result beat per sample beat, one sample per clock sustained while the
// output is not stalled. A sample is captured in an input register; the two
// velocity products, the sums and magnitudes, both hysteresis compares and
// the code mapping are worked out in one combinational pass that loads the
// result register, from which the gaze code is issued. The previous gaze is
// held in a register next to the result register and is read and updated in
// that same pass, so back-to-back samples each see the gaze of the one
// before. A stalled output holds the result register, and once the input
// register is full as well, in_tready drops in the same cycle. Configuration
// written over APB takes effect for samples accepted from the next cycle on.
module gaze_direction_hysteresis_quantizer #(
  parameter int SAMPLE_BITS = gdhq_pkg::SAMPLE_BITS_DEF,
  localparam int IN_DW      = ((6 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // tdata fields from bit 0: pitch, yaw, roll, vel_x, vel_y, turn_rate.
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [IN_DW-1:0]            in_tdata,
  // tuser fields from bit 0: critical_flag.
  input  logic [0:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // tdata fields from bit 0: gaze_code.
  output logic [7:0]                  out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [gdhq_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [gdhq_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [gdhq_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  localparam int W    = SAMPLE_BITS;
  localparam int PW   = W + 16;
  localparam int MCW  = W + gdhq_pkg::THR_W;
  localparam int CMPW = W + 20;

  gdhq_pkg::cfg_t cfg;

  gdhq_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  // A register can take a beat when empty or draining.
  logic a_vld_r, out_vld_r;
  logic rdy_a, rdy_o;

  assign rdy_o     = !out_vld_r || out_tready;
  assign rdy_a     = !a_vld_r || rdy_o;
  assign in_tready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (rdy_a) a_vld_r   <= in_tvalid;
      if (rdy_o) out_vld_r <= a_vld_r;
    end
  end

  // Input register.
  logic signed [W-1:0] a_pitch_r, a_yaw_r, a_roll_r, a_vx_r, a_vy_r, a_wz_r;
  logic                a_crit_r;

  always_ff @(posedge clk) begin
    if (rdy_a && in_tvalid) begin
      a_pitch_r <= in_tdata[0*W +: W];
      a_yaw_r   <= in_tdata[1*W +: W];
      a_roll_r  <= in_tdata[2*W +: W];
      a_vx_r    <= in_tdata[3*W +: W];
      a_vy_r    <= in_tdata[4*W +: W];
      a_wz_r    <= in_tdata[5*W +: W];
      a_crit_r  <= in_tuser[0];
    end
  end

  // Weighted velocities, tilt difference, motion test, then the selected
  // horizontal value and both magnitudes. The vertical value is minus
  // pitch, so it is positive exactly when pitch is negative.
  logic signed [PW-1:0] pvy, pwz, hval;
  logic signed [W:0]    diff;
  logic [W-1:0]         mvx, mvy, mwz, mag_v;
  logic [PW-1:0]        mag_h;
  logic                 moving, pos_h, pos_v;

  always_comb begin
    pvy    = a_vy_r * $signed({1'b0, cfg.vy_gain});
    pwz    = a_wz_r * $signed({1'b0, cfg.wz_gain});
    diff   = {a_yaw_r[W-1], a_yaw_r} - {a_roll_r[W-1], a_roll_r};
    mvx    = a_vx_r[W-1] ? W'(-a_vx_r) : W'(a_vx_r);
    mvy    = a_vy_r[W-1] ? W'(-a_vy_r) : W'(a_vy_r);
    mwz    = a_wz_r[W-1] ? W'(-a_wz_r) : W'(a_wz_r);
    moving = (MCW'(mvx) >= MCW'(cfg.zero_tol)) ||
             (MCW'(mvy) >= MCW'(cfg.zero_tol)) ||
             (MCW'(mwz) >= MCW'(cfg.zero_tol));
    hval   = moving ? (pvy + pwz) : {{(PW-W-1){diff[W]}}, diff};
    mag_h  = hval[PW-1] ? PW'(-hval) : PW'(hval);
    pos_h  = !hval[PW-1] && (hval != '0);
    mag_v  = a_pitch_r[W-1] ? W'(-a_pitch_r) : W'(a_pitch_r);
    pos_v  = a_pitch_r[W-1];
  end

  // Compare and map. Hold compares are |v|*256 against enter*ratio; for
  // the velocity sum, whose enter level carries a 4096 scale, that reduces
  // exactly to |v| against 16*deadband*ratio.
  logic [gdhq_pkg::CODE_W-1:0] last_gaze_r, out_gaze_r, code_nxt;
  logic [CMPW-1:0]             enter_h, a_hold_h, hold_h;
  gdhq_pkg::sign_t             sv, sh;

  always_comb begin
    enter_h  = moving ? CMPW'({cfg.deadband, 12'b0}) : CMPW'(cfg.tilt_thr);
    a_hold_h = moving ? CMPW'(mag_h) : CMPW'({mag_h[W:0], 8'b0});
    hold_h   = moving ? CMPW'({cfg.deadband_hold, 4'b0}) : CMPW'(cfg.tilt_hold);
  end

  gdhq_hyst #(.CMPW(CMPW)) u_hyst_v (
    .a_enter (CMPW'(mag_v)),
    .enter   (CMPW'(cfg.pitch_thr)),
    .a_hold  (CMPW'({mag_v, 8'b0})),
    .hold    (CMPW'(cfg.pitch_hold)),
    .pos     (pos_v),
    .prev    (gdhq_pkg::vert_of_code(last_gaze_r)),
    .q       (sv)
  );

  gdhq_hyst #(.CMPW(CMPW)) u_hyst_h (
    .a_enter (CMPW'(mag_h)),
    .enter   (enter_h),
    .a_hold  (a_hold_h),
    .hold    (hold_h),
    .pos     (pos_h),
    .prev    (gdhq_pkg::horz_of_code(last_gaze_r)),
    .q       (sh)
  );

  assign code_nxt = a_crit_r ? gdhq_pkg::GAZE_CENTER : gdhq_pkg::code_of_signs(sv, sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_gaze_r <= gdhq_pkg::GAZE_CENTER;
    end else if (rdy_o && a_vld_r) begin
      last_gaze_r <= code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && a_vld_r) begin
      out_gaze_r <= code_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0, out_gaze_r};

  // The fed-back gaze must be exactly the code just placed in the result.
  a_last_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy_o && a_vld_r) |=> (last_gaze_r == out_gaze_r))
    else $error("last gaze register differs from the result just issued");

  a_crit_center: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy_o && a_vld_r && a_crit_r) |=> (out_gaze_r == gdhq_pkg::GAZE_CENTER))
    else $error("battery-critical sample did not give center gaze");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_gaze_r <= gdhq_pkg::GAZE_DOWN_RIGHT))
    else $error("gaze code out of range");

endmodule

// File: rtl/gdhq_cfg.sv
// APB-style register file for the gaze quantizer, plus the registered
// hold-level products. Depends on gdhq_pkg.
module gdhq_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [gdhq_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [gdhq_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [gdhq_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output gdhq_pkg::cfg_t                cfg_o
);

  logic [gdhq_pkg::THR_W-1:0]   pitch_thr_r, tilt_thr_r, deadband_r;
  logic [gdhq_pkg::THR_W-1:0]   vy_gain_r, wz_gain_r, zero_tol_r;
  logic [gdhq_pkg::RATIO_W-1:0] exit_rat_r;
  logic [gdhq_pkg::HOLD_W-1:0]  pitch_hold_r, tilt_hold_r, deadband_hold_r;
  logic [gdhq_pkg::IDX_W-1:0]   idx;
  logic                         wr_en;

  assign idx        = cfg_paddr[gdhq_pkg::CFG_AW-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_thr_r <= gdhq_pkg::RST_PITCH_THR;
      tilt_thr_r  <= gdhq_pkg::RST_TILT_THR;
      deadband_r  <= gdhq_pkg::RST_DEADBAND;
      exit_rat_r  <= gdhq_pkg::RST_EXIT_RAT;
      vy_gain_r   <= gdhq_pkg::RST_VY_GAIN;
      wz_gain_r   <= gdhq_pkg::RST_WZ_GAIN;
      zero_tol_r  <= gdhq_pkg::RST_ZERO_TOL;
    end else if (wr_en) begin
      unique case (idx)
        gdhq_pkg::REG_PITCH_THR: pitch_thr_r <= cfg_pwdata[gdhq_pkg::THR_W-1:0];
        gdhq_pkg::REG_TILT_THR:  tilt_thr_r  <= cfg_pwdata[gdhq_pkg::THR_W-1:0];
        gdhq_pkg::REG_DEADBAND:  deadband_r  <= cfg_pwdata[gdhq_pkg::THR_W-1:0];
        gdhq_pkg::REG_EXIT_RAT:  exit_rat_r  <= cfg_pwdata[gdhq_pkg::RATIO_W-1:0];
        gdhq_pkg::REG_VY_GAIN:   vy_gain_r   <= cfg_pwdata[gdhq_pkg::THR_W-1:0];
        gdhq_pkg::REG_WZ_GAIN:   wz_gain_r   <= cfg_pwdata[gdhq_pkg::THR_W-1:0];
        gdhq_pkg::REG_ZERO_TOL:  zero_tol_r  <= cfg_pwdata[gdhq_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // The products are registered behind the registers; a sample accepted after
  // the write reaches the compare only from the input register, so it already
  // sees them.
  always_ff @(posedge clk) begin
    pitch_hold_r    <= gdhq_pkg::HOLD_W'(pitch_thr_r) * gdhq_pkg::HOLD_W'(exit_rat_r);
    tilt_hold_r     <= gdhq_pkg::HOLD_W'(tilt_thr_r) * gdhq_pkg::HOLD_W'(exit_rat_r);
    deadband_hold_r <= gdhq_pkg::HOLD_W'(deadband_r) * gdhq_pkg::HOLD_W'(exit_rat_r);
  end

  always_comb begin
    unique case (idx)
      gdhq_pkg::REG_PITCH_THR: cfg_prdata = gdhq_pkg::CFG_DW'(pitch_thr_r);
      gdhq_pkg::REG_TILT_THR:  cfg_prdata = gdhq_pkg::CFG_DW'(tilt_thr_r);
      gdhq_pkg::REG_DEADBAND:  cfg_prdata = gdhq_pkg::CFG_DW'(deadband_r);
      gdhq_pkg::REG_EXIT_RAT:  cfg_prdata = gdhq_pkg::CFG_DW'(exit_rat_r);
      gdhq_pkg::REG_VY_GAIN:   cfg_prdata = gdhq_pkg::CFG_DW'(vy_gain_r);
      gdhq_pkg::REG_WZ_GAIN:   cfg_prdata = gdhq_pkg::CFG_DW'(wz_gain_r);
      gdhq_pkg::REG_ZERO_TOL:  cfg_prdata = gdhq_pkg::CFG_DW'(zero_tol_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  always_comb begin
    cfg_o.pitch_thr     = pitch_thr_r;
    cfg_o.tilt_thr      = tilt_thr_r;
    cfg_o.deadband      = deadband_r;
    cfg_o.vy_gain       = vy_gain_r;
    cfg_o.wz_gain       = wz_gain_r;
    cfg_o.zero_tol      = zero_tol_r;
    cfg_o.pitch_hold    = pitch_hold_r;
    cfg_o.tilt_hold     = tilt_hold_r;
    cfg_o.deadband_hold = deadband_hold_r;
  end

endmodule

// File: rtl/gdhq_hyst.sv
// One hysteresis sign quantizer: enter-level compare, then hold-band
// compare against the previous sign. Depends on gdhq_pkg.
module gdhq_hyst #(
  parameter int CMPW = 36
) (
  input  logic [CMPW-1:0] a_enter,
  input  logic [CMPW-1:0] enter,
  input  logic [CMPW-1:0] a_hold,
  input  logic [CMPW-1:0] hold,
  input  logic            pos,
  input  gdhq_pkg::sign_t prev,
  output gdhq_pkg::sign_t q
);

  // A value of zero arrives with pos clear, so it counts as negative
  // in both compares.
  always_comb begin
    priority if (a_enter >= enter) begin
      q = '{nz: 1'b1, pos: pos};
    end else if (prev.nz && (a_hold >= hold) && (pos == prev.pos)) begin
      q = prev;
    end else begin
      q = '{nz: 1'b0, pos: 1'b0};
    end
  end

endmodule
